/* src/mbip_pkg.sv */
// Shared types and constants for the multi-base integer parser.
// Holds the character codes, the character class record and the parser phases.
// Depends on nothing.
`default_nettype none

package mbip_pkg;

   localparam int CHAR_W  = 16;
   localparam int VALUE_W = 64;
   localparam int DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
   localparam logic [CHAR_W-1:0] CH_BAR   = 16'h007C;
   localparam logic [CHAR_W-1:0] CH_LX    = 16'h0078;
   localparam logic [CHAR_W-1:0] CH_UX    = 16'h0058;
   localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
   localparam logic [CHAR_W-1:0] CH_SEVEN = 16'h0037;
   localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
   localparam logic [CHAR_W-1:0] CH_LA    = 16'h0061;
   localparam logic [CHAR_W-1:0] CH_LF    = 16'h0066;
   localparam logic [CHAR_W-1:0] CH_UA    = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_UF    = 16'h0046;

   localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 4'd9;

   typedef enum logic [2:0] {
      KIND_NUL,
      KIND_BAR,
      KIND_XCH,
      KIND_MINUS,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [DIGIT_W-1:0]  digit;
      logic                is_dec;
      logic                is_oct;
      logic                is_hex;
   } class_type;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_ZERO  = 3'd1,
      PH_HEX   = 3'd2,
      PH_OCT   = 3'd3,
      PH_DEC   = 3'd4,
      PH_STOP  = 3'd5
   } phase_type;

endpackage

`default_nettype wire

/* src/multi_base_int_parser_top.sv */
// Multi-base integer parser: one character per transfer in, one 64-bit value
// out per terminated string. An accepted terminator is registered in the queue;
// the back end then pops it and registers the result and rsp_tvalid.
// Throughput: one character per cycle while the queue has room, set by the update
// of the term accumulator; a terminator waits while an older result is held.
// Reset (synchronous, active high) empties the queue and the result register
// and returns the parser to the start of a term with zero totals.
`default_nettype none

module multi_base_int_parser_top #(
   parameter int CHAR_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [15:0] ch
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic signed [63:0] rsp_tdata   // [63:0] value
);
   import mbip_pkg::*;

   class_type front_class;
   class_type queue_head;
   logic      queue_full;
   logic      queue_not_empty;
   logic      queue_pop;

   assign req_tready = !queue_full;

   mbip_front #(
      .CHAR_BITS (CHAR_BITS)
   ) u_front (
      .char_in   (req_tdata),
      .class_out (front_class)
   );

   mbip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (front_class),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (queue_pop),
      .pop_data  (queue_head)
   );

   mbip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (queue_head),
      .item_pop   (queue_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* src/mbip_front.sv */
// Front end of the parser: masks each character and classifies it.
// Produces a class record for the queue. Depends on mbip_pkg.
`default_nettype none

module mbip_front #(
   parameter int CHAR_BITS = 16
) (
   input  wire logic [mbip_pkg::CHAR_W-1:0] char_in,
   output mbip_pkg::class_type               class_out
);
   import mbip_pkg::*;

   logic [CHAR_W-1:0] c;
   logic              dec_range;
   logic              lower_hex;
   logic              upper_hex;

   always_comb begin
      c = CHAR_W'(char_in[CHAR_BITS-1:0]);
      dec_range = (c >= CH_ZERO) && (c <= CH_NINE);
      lower_hex = (c >= CH_LA) && (c <= CH_LF);
      upper_hex = (c >= CH_UA) && (c <= CH_UF);

      class_out.is_dec = dec_range;
      class_out.is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);
      class_out.is_hex = dec_range || lower_hex || upper_hex;
      // Letters a-f and A-F both carry 1..6 in the low nibble.
      if (dec_range) begin
         class_out.digit = c[DIGIT_W-1:0];
      end else begin
         class_out.digit = c[DIGIT_W-1:0] + LETTER_OFFSET;
      end

      priority if (c == CH_NUL) begin
         class_out.kind = KIND_NUL;
      end else if (c == CH_BAR) begin
         class_out.kind = KIND_BAR;
      end else if ((c == CH_LX) || (c == CH_UX)) begin
         class_out.kind = KIND_XCH;
      end else if (c == CH_MINUS) begin
         class_out.kind = KIND_MINUS;
      end else begin
         class_out.kind = KIND_OTHER;
      end
   end

endmodule

`default_nettype wire

/* src/mbip_queue.sv */
// Two-entry queue of classified characters between front and back ends.
// Depends on mbip_pkg for the class record.
`default_nettype none

module mbip_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  mbip_pkg::class_type       push_data,
   output logic                      full,
   output logic                      not_empty,
   input  wire logic                 pop,
   output mbip_pkg::class_type       pop_data
);
   import mbip_pkg::*;

   class_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      pop_data  = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* src/mbip_back.sv */
// Back end of the parser: runs the phase machine, accumulates terms and
// drives the registered result. Depends on mbip_pkg.
`default_nettype none

module mbip_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   input  mbip_pkg::class_type                 item,
   output logic                                item_pop,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic signed [mbip_pkg::VALUE_W-1:0] out_value
);
   import mbip_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W-1:0]  total_ff, total_in;
   logic                out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]  out_value_ff, out_value_in;

   logic [VALUE_W-1:0]  digit_ext;
   logic [VALUE_W-1:0]  term;
   logic [VALUE_W-1:0]  total_with_term;
   logic                end_term;
   logic                phase_live;

   always_comb begin
      digit_ext       = VALUE_W'(item.digit);
      term            = neg_ff ? (VALUE_W'(0) - acc_ff) : acc_ff;
      total_with_term = total_ff | term;
      phase_live      = (phase_ff != PH_STOP) && (phase_ff <= PH_DEC);

      // A terminator waits while the result register is still occupied.
      item_pop = item_valid &&
                 ((item.kind != KIND_NUL) || !out_valid_ff || out_ready);

      phase_in     = phase_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_value_in = out_value_ff;
      end_term     = 1'b0;

      if (item_pop) begin
         if (item.kind == KIND_NUL) begin
            out_valid_in = 1'b1;
            out_value_in = phase_live ? total_with_term : total_ff;
            phase_in     = PH_START;
            acc_in       = '0;
            neg_in       = 1'b0;
            total_in     = '0;
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  if (item.is_dec && (item.digit == '0)) begin
                     acc_in   = '0;
                     phase_in = PH_ZERO;
                  end else if (item.kind == KIND_MINUS) begin
                     neg_in   = 1'b1;
                     acc_in   = '0;
                     phase_in = PH_DEC;
                  end else if (item.is_dec) begin
                     acc_in   = digit_ext;
                     phase_in = PH_DEC;
                  end else begin
                     end_term = 1'b1;
                  end
               end
               PH_ZERO: begin
                  if (item.kind == KIND_XCH) begin
                     phase_in = PH_HEX;
                  end else if (item.is_oct) begin
                     acc_in   = digit_ext;
                     phase_in = PH_OCT;
                  end else if (item.is_dec) begin
                     acc_in   = digit_ext;
                     phase_in = PH_DEC;
                  end else begin
                     end_term = 1'b1;
                  end
               end
               PH_HEX: begin
                  if (item.is_hex) begin
                     acc_in = {acc_ff[VALUE_W-5:0], 4'b0000} + digit_ext;
                  end else begin
                     end_term = 1'b1;
                  end
               end
               PH_OCT: begin
                  if (item.is_oct) begin
                     acc_in = {acc_ff[VALUE_W-4:0], 3'b000} + digit_ext;
                  end else begin
                     end_term = 1'b1;
                  end
               end
               PH_DEC: begin
                  if (item.is_dec) begin
                     // Times ten as eight plus two, then the new digit.
                     acc_in = {acc_ff[VALUE_W-4:0], 3'b000} +
                              {acc_ff[VALUE_W-2:0], 1'b0} + digit_ext;
                  end else begin
                     end_term = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            if (end_term) begin
               total_in = total_with_term;
               acc_in   = '0;
               neg_in   = 1'b0;
               phase_in = (item.kind == KIND_BAR) ? PH_START : PH_STOP;
            end
         end
      end

      out_valid = out_valid_ff;
      out_value = out_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
   end

endmodule

`default_nettype wire

/* verif/tb_multi_base_int_parser_top.sv */
// Self-checking testbench for multi_base_int_parser_top: streams character codes
// in, predicts each terminated string's 64-bit value and checks every result.
// Depends on mbip_pkg and the parser top level only.
`timescale 1ns / 1ps

module tb_multi_base_int_parser_top;

   import mbip_pkg::*;

   localparam int          CHAR_BITS    = 16;
   localparam logic [15:0] CHAR_MASK    = 16'((32'd1 << CHAR_BITS) - 1);
   localparam logic [63:0] DEC_RADIX    = 64'd10;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          RANDOM_CHARS = 1800;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          NUM_ROWS     = 24;

   typedef struct {
      string       text;    // a '~' stands for the wide code below
      logic [15:0] wide;
      bit          known;
      logic [63:0] value;
   } directed_row_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] ch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic signed [63:0] rsp_tdata; // [63:0] value

   // Parser state as predicted by the testbench.
   phase_type   parse_phase   = PH_START;
   logic [63:0] term_value    = '0;
   logic [63:0] or_total      = '0;
   bit          term_negative = 1'b0;

   logic [63:0] pending_totals[$];
   int          failures   = 0;
   int          chars_sent = 0;
   int          stall_left = 0;
   bit          sink_calm  = 1'b0;
   int unsigned sink_roll;
   string       hex_digits = "0123456789abcdefABCDEF";

   directed_row_t directed_rows [0:NUM_ROWS-1] = '{
      '{"",                        16'h0000, 1'b1, 64'd0},
      '{"0",                       16'h0000, 1'b1, 64'd0},
      '{"|||",                     16'h0000, 1'b1, 64'd0},
      '{"0x",                      16'h0000, 1'b1, 64'd0},
      '{"-",                       16'h0000, 1'b1, 64'd0},
      '{"--5",                     16'h0000, 1'b1, 64'd0},
      '{"0xFFFFFFFFFFFFFFFF",      16'h0000, 1'b1, ALL_ONES},
      '{"0xabcdef|0XABCDEF",       16'h0000, 1'b1, 64'hAB_CDEF},
      '{"017",                     16'h0000, 1'b1, 64'd15},
      '{"09",                      16'h0000, 1'b1, 64'd9},
      '{"-1",                      16'h0000, 1'b1, ALL_ONES},
      '{"18446744073709551615",    16'h0000, 1'b1, ALL_ONES},
      '{"18446744073709551616",    16'h0000, 1'b1, 64'd0},
      '{"-9223372036854775808",    16'h0000, 1'b1, 64'h8000_0000_0000_0000},
      '{"01777777777777777777777", 16'h0000, 1'b1, ALL_ONES},
      '{"5|8|0x1;7",               16'h0000, 1'b1, 64'd13},
      '{"12~34",                   16'hFFFF, 1'b1, 64'd12},
      '{"7~1",                     16'h0131, 1'b1, 64'd7},
      '{"0xz5",                    16'h0000, 1'b1, 64'd0},
      '{"-0x5",                    16'h0000, 1'b1, 64'd0},
      '{"3 |4",                    16'h0000, 1'b1, 64'd3},
      '{"123|0x7f0|-42",           16'h0000, 1'b0, 64'd0},
      '{"0X|0|-|0x10",             16'h0000, 1'b0, 64'd0},
      '{"0x8|07|8|-0",             16'h0000, 1'b0, 64'd0}
   };

   multi_base_int_parser_top #(
      .CHAR_BITS (CHAR_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic void close_term();
      logic [63:0] signed_term;
      signed_term   = term_negative ? (64'd0 - term_value) : term_value;
      or_total      = or_total | signed_term;
      term_value    = '0;
      term_negative = 1'b0;
   endfunction

   function automatic void end_term(input logic [15:0] c);
      close_term();
      parse_phase = (c == CH_BAR) ? PH_START : PH_STOP;
   endfunction

   // Advances the predicted parser by one character; returns 1 when the
   // character is a terminator, with the emitted total in total.
   function automatic bit parse_char(input logic [15:0] code, output logic [63:0] total);
      logic [15:0] c;
      bit          is_dec;
      bit          is_oct;
      bit          is_hex;
      logic [63:0] hex_val;
      c       = code & CHAR_MASK;
      total   = '0;
      is_dec  = (c >= CH_ZERO) && (c <= CH_NINE);
      is_oct  = (c >= CH_ZERO) && (c <= CH_SEVEN);
      is_hex  = 1'b1;
      hex_val = '0;
      if (is_dec) begin
         hex_val = 64'(c - CH_ZERO);
      end else if (c >= CH_LA && c <= CH_LF) begin
         hex_val = 64'(c - CH_LA) + 64'd10;
      end else if (c >= CH_UA && c <= CH_UF) begin
         hex_val = 64'(c - CH_UA) + 64'd10;
      end else begin
         is_hex = 1'b0;
      end

      if (c == CH_NUL) begin
         if (parse_phase != PH_STOP && parse_phase <= PH_DEC) close_term();
         total         = or_total;
         parse_phase   = PH_START;
         term_value    = '0;
         or_total      = '0;
         term_negative = 1'b0;
         return 1'b1;
      end

      case (parse_phase)
         PH_START: begin
            if (c == CH_ZERO) begin
               term_value  = '0;
               parse_phase = PH_ZERO;
            end else if (c == CH_MINUS) begin
               term_negative = 1'b1;
               term_value    = '0;
               parse_phase   = PH_DEC;
            end else if (is_dec) begin
               term_value  = 64'(c - CH_ZERO);
               parse_phase = PH_DEC;
            end else begin
               end_term(c);
            end
         end
         PH_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
               parse_phase = PH_HEX;
            end else if (is_oct) begin
               term_value  = 64'(c - CH_ZERO);
               parse_phase = PH_OCT;
            end else if (is_dec) begin
               term_value  = 64'(c - CH_ZERO);
               parse_phase = PH_DEC;
            end else begin
               end_term(c);
            end
         end
         PH_HEX: begin
            if (is_hex) term_value = (term_value << 4) + hex_val;
            else end_term(c);
         end
         PH_OCT: begin
            if (is_oct) term_value = (term_value << 3) + 64'(c - CH_ZERO);
            else end_term(c);
         end
         PH_DEC: begin
            if (is_dec) term_value = term_value * DEC_RADIX + 64'(c - CH_ZERO);
            else end_term(c);
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   function automatic logic [15:0] random_noise_char();
      int pick;
      pick = $urandom_range(0, 2);
      if (pick == 0) return 16'($urandom_range(0, 16'hFFFF));
      if (pick == 1) return 16'($urandom_range(1, 127));
      // Wide code whose low byte looks like an ordinary character.
      return {8'($urandom_range(1, 255)), 8'($urandom_range(8'h30, 8'h7C))};
   endfunction

   // Sends one string, terminator included. A predicted total is queued at
   // each accepted terminator; rows with a typed-in value queue that instead.
   task automatic send_string(input logic [15:0] codes[$], input bit calm,
                              input bit known, input logic [63:0] literal);
      logic [63:0] total;
      int          gap;
      int          roll;
      foreach (codes[i]) begin
         roll = $urandom_range(0, 99);
         if (calm || roll < 70) gap = 0;
         else if (roll < 95) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 30);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= codes[i];
         do @(posedge clock); while (!req_tready);
         chars_sent++;
         if (parse_char(codes[i], total)) pending_totals.push_back(known ? literal : total);
      end
   endtask

   // Result side: checks each transfer and stalls at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_totals.size() == 0) begin
            $error("value arrived with nothing expected: %h", rsp_tdata);
            failures++;
         end else begin
            if (rsp_tdata !== pending_totals[0]) begin
               $error("value mismatch: expected %h, actual %h", pending_totals[0], rsp_tdata);
               failures++;
            end
            void'(pending_totals.pop_front());
         end
      end

      if ($urandom_range(0, 299) == 0) sink_calm <= !sink_calm;
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         sink_roll = $urandom_range(0, 99);
         if (sink_calm || sink_roll < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= (sink_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         end
      end
   end

   initial begin : stimulus
      logic [15:0] codes[$];
      int          n_terms;
      int          len;
      int          roll;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         codes.delete();
         for (int i = 0; i < directed_rows[r].text.len(); i++) begin
            codes.push_back(directed_rows[r].text[i] == "~" ? directed_rows[r].wide
                                                           : {8'h00, directed_rows[r].text[i]});
         end
         codes.push_back(CH_NUL);
         send_string(codes, 1'b0, directed_rows[r].known, directed_rows[r].value);
      end

      // Mostly well-formed term lists with random digits, plus noise and
      // strings that stop early and carry trailing garbage.
      while (chars_sent < RANDOM_CHARS) begin
         codes.delete();
         n_terms = $urandom_range(1, 4);
         for (int t = 0; t < n_terms; t++) begin
            if (t != 0) codes.push_back(CH_BAR);
            roll = $urandom_range(0, 9);
            if (roll < 3) begin
               codes.push_back(CH_ZERO);
               codes.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 8);
               repeat (len) codes.push_back({8'h00, hex_digits[$urandom_range(0, 21)]});
            end else if (roll < 5) begin
               codes.push_back(CH_ZERO);
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 24) : $urandom_range(0, 8);
               repeat (len) codes.push_back(CH_ZERO + 16'($urandom_range(0, 7)));
            end else if (roll < 8) begin
               if ($urandom_range(0, 2) == 0) codes.push_back(CH_MINUS);
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 22) : $urandom_range(0, 6);
               repeat (len) codes.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
            end else if (roll == 9) begin
               repeat ($urandom_range(1, 3)) codes.push_back(random_noise_char());
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            codes.push_back(random_noise_char());
            repeat ($urandom_range(0, 4)) codes.push_back(16'($urandom_range(1, 16'hFFFF)));
         end
         codes.push_back(CH_NUL);
         send_string(codes, $urandom_range(0, 3) == 0, 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
src/mbip_pkg.sv
src/mbip_front.sv
src/mbip_queue.sv
src/mbip_back.sv
src/multi_base_int_parser_top.sv
verif/tb_multi_base_int_parser_top.sv
